>>> rtl/core/accel_motion_intent_detector_unit_defines.svh
// Assertion helpers shared by the RTL of the motion intent detector.
`ifndef ACCEL_MOTION_INTENT_DETECTOR_UNIT_DEFINES_SVH
`define ACCEL_MOTION_INTENT_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define AMID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define AMID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/amid_pkg.sv
`default_nettype none

package amid_pkg;

  // Square root unit widths
  localparam int SQRT_IN_W = 34;
  localparam int ROOT_W    = 17;

  // Axis index of z, the last axis processed
  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Register reset values
  localparam logic [15:0] ALPHA_RST      = 16'd60681;
  localparam logic [16:0] ENTER_THR_RST  = 17'd1982;
  localparam logic [16:0] EXIT_THR_RST   = 17'd1475;
  localparam logic [3:0]  ENTER_DEB_RST  = 4'd5;
  localparam logic [3:0]  EXIT_DEB_RST   = 4'd8;
  localparam logic [15:0] INTENT_MIN_RST = 16'd350;
  localparam logic [15:0] GAP_TOL_RST    = 16'd60;
  localparam logic [15:0] REFRACT_RST    = 16'd400;

  typedef enum logic [2:0] {
    CFG_ALPHA      = 3'd0,
    CFG_ENTER_THR  = 3'd1,
    CFG_EXIT_THR   = 3'd2,
    CFG_ENTER_DEB  = 3'd3,
    CFG_EXIT_DEB   = 3'd4,
    CFG_INTENT_MIN = 3'd5,
    CFG_GAP_TOL    = 3'd6,
    CFG_REFRACT    = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_GRAV,
    ST_MUL_D,
    ST_MUL_R,
    ST_LIN,
    ST_RING,
    ST_DIV,
    ST_HYST,
    ST_INTENT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] time_ms;
  } in_word_t;

  typedef struct packed {
    logic        is_moving;
    logic        intent_flag;
    logic [16:0] smoothed_linear_mag;
    logic [16:0] total_mag;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/core/accel_motion_intent_detector_unit.sv
`default_nettype none

// Motion intent detector for one three-axis accelerometer stream.
//
// Input channel: in_valid_i / in_stall_o carry one word per sample (three
// signed axes in counts, 16384 per g, plus a wrapping ms timestamp). A word
// is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i carry one word per sample:
// moving state, intent flag, smoothed linear magnitude, total magnitude.
// Sequence: each of the 3 axes in turn on the shared multiplier, a wait on
// the linear square root, the ring update, a wait while the total-magnitude
// root runs with the divide by length done as one reciprocal multiply
// inside that wait, then hysteresis, intent and emit steps; out_valid_o
// rises as emit completes. in_stall_o is high from acceptance until the
// sequencer is back in idle, so no new sample is taken before it is done.
// A finished word sits in the output register; the next sample can be
// taken meanwhile, and the sequencer only waits in its last step if the
// previous word has not been taken. Holding out_stall_i just holds the word.
// Reset: gravity estimate goes to (0, 0, 1 g), the average ring, tallies,
// times and flags clear, registers take their defaults; no output pending.
// Registers sit on the APB port at byte address 4 * index.
module accel_motion_intent_detector_unit #(
  parameter int AVG_LENGTH        = 5,
  parameter int GRAVITY_FRAC_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // sample channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire amid_pkg::in_word_t   in_word_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output amid_pkg::out_word_t       out_word_o,
  // register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

`include "accel_motion_intent_detector_unit_defines.svh"

  localparam int F   = GRAVITY_FRAC_BITS;
  localparam int GW  = 17 + F;             // gravity estimate width
  localparam int MW  = GW + 1;             // multiplier operand width
  localparam int PW  = 2 * MW;             // product width
  localparam int SSW = PW + 2;             // sum of three squares
  localparam int RTW = 17 + $clog2(AVG_LENGTH);
  localparam int RPW = (AVG_LENGTH > 1) ? $clog2(AVG_LENGTH) : 1;
  // ring total / length as (total * RCP_M) >> RCP_K, exact over the total's range
  localparam int RCP_K = 17 + 2 * $clog2(AVG_LENGTH);
  localparam int RCP_M = ((1 << RCP_K) + AVG_LENGTH - 1) / AVG_LENGTH;

  localparam logic signed [GW-1:0] GRAV_Z_RST = GW'(16384) << F;

  // ---------------------------------------------------------------- registers
  logic [15:0] alpha_q;
  logic [16:0] enter_thr_q, exit_thr_q;
  logic [3:0]  enter_deb_q, exit_deb_q;
  logic [15:0] intent_min_q, gap_q, refr_q;

  logic               cfg_wr;
  amid_pkg::cfg_reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = amid_pkg::cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      <= amid_pkg::ALPHA_RST;
      enter_thr_q  <= amid_pkg::ENTER_THR_RST;
      exit_thr_q   <= amid_pkg::EXIT_THR_RST;
      enter_deb_q  <= amid_pkg::ENTER_DEB_RST;
      exit_deb_q   <= amid_pkg::EXIT_DEB_RST;
      intent_min_q <= amid_pkg::INTENT_MIN_RST;
      gap_q        <= amid_pkg::GAP_TOL_RST;
      refr_q       <= amid_pkg::REFRACT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        amid_pkg::CFG_ALPHA:      alpha_q      <= pwdata[15:0];
        amid_pkg::CFG_ENTER_THR:  enter_thr_q  <= pwdata[16:0];
        amid_pkg::CFG_EXIT_THR:   exit_thr_q   <= pwdata[16:0];
        amid_pkg::CFG_ENTER_DEB:  enter_deb_q  <= pwdata[3:0];
        amid_pkg::CFG_EXIT_DEB:   exit_deb_q   <= pwdata[3:0];
        amid_pkg::CFG_INTENT_MIN: intent_min_q <= pwdata[15:0];
        amid_pkg::CFG_GAP_TOL:    gap_q        <= pwdata[15:0];
        amid_pkg::CFG_REFRACT:    refr_q       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      amid_pkg::CFG_ALPHA:      prdata = 32'(alpha_q);
      amid_pkg::CFG_ENTER_THR:  prdata = 32'(enter_thr_q);
      amid_pkg::CFG_EXIT_THR:   prdata = 32'(exit_thr_q);
      amid_pkg::CFG_ENTER_DEB:  prdata = 32'(enter_deb_q);
      amid_pkg::CFG_EXIT_DEB:   prdata = 32'(exit_deb_q);
      amid_pkg::CFG_INTENT_MIN: prdata = 32'(intent_min_q);
      amid_pkg::CFG_GAP_TOL:    prdata = 32'(gap_q);
      amid_pkg::CFG_REFRACT:    prdata = 32'(refr_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  amid_pkg::state_e state_q, state_d;
  amid_pkg::in_word_t in_q;
  logic [1:0]              axis_q;
  logic signed [GW-1:0]    grav_q [3];
  logic signed [PW:0]      acc_q;
  logic [SSW-1:0]          lin_sum_q;
  logic [31:0]             raw_sum_q;
  logic [16:0]             ring_q [AVG_LENGTH];
  logic [RPW-1:0]          ring_pos_q;
  logic [RTW-1:0]          ring_total_q;
  logic [16:0]             num_q;      // ring total over length
  logic                    moving_q, intent_q;
  logic [3:0]              enter_tally_q, exit_tally_q;
  logic [31:0]             bout_q, last_motion_q, last_intent_q;
  logic                    out_valid_q;
  amid_pkg::out_word_t     out_word_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // ---------------------------------------------------------------- shared multiplier
  logic signed [15:0]   cur_a;
  logic signed [MW-1:0] a_m, as_m, g_m, d_m, beta_m, op1, op2;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   acc_sh;

  always_comb begin
    case (axis_q)
      2'd0:    cur_a = in_q.accel_x;
      2'd1:    cur_a = in_q.accel_y;
      default: cur_a = in_q.accel_z;
    endcase
  end

  assign a_m    = {{(MW-16){cur_a[15]}}, cur_a};
  assign as_m   = a_m <<< F;
  assign g_m    = {{(MW-GW){grav_q[axis_q][GW-1]}}, grav_q[axis_q]};
  assign d_m    = as_m - g_m;
  assign beta_m = MW'(17'h10000 - {1'b0, alpha_q});

  always_comb begin
    case (state_q)
      amid_pkg::ST_MUL_A: begin op1 = MW'({1'b0, alpha_q}); op2 = g_m;  end
      amid_pkg::ST_MUL_B: begin op1 = beta_m;               op2 = as_m; end
      amid_pkg::ST_MUL_D: begin op1 = d_m;                  op2 = d_m;  end
      amid_pkg::ST_DIV:   begin op1 = MW'(ring_total_q);    op2 = MW'(RCP_M); end
      default:            begin op1 = a_m;                  op2 = a_m;  end
    endcase
  end

  assign prod   = op1 * op2;
  assign acc_sh = acc_q >>> 16;

  // ---------------------------------------------------------------- square root
  logic                             sq_start, sq_busy;
  logic [amid_pkg::SQRT_IN_W-1:0]   sq_rad;
  logic [amid_pkg::ROOT_W-1:0]      sq_root;
  logic [SSW-1:0]                   lin_shift;

  assign lin_shift = lin_sum_q >> (2 * F);
  assign sq_start  = ((state_q == amid_pkg::ST_MUL_R) && (axis_q == amid_pkg::AXIS_LAST)) ||
                     (state_q == amid_pkg::ST_RING);
  assign sq_rad    = (state_q == amid_pkg::ST_RING) ?
                     amid_pkg::SQRT_IN_W'(raw_sum_q) : lin_shift[amid_pkg::SQRT_IN_W-1:0];

  amid_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .busy_o     (sq_busy),
    .root_o     (sq_root)
  );

  // ---------------------------------------------------------------- ring
  logic [RTW-1:0] ring_total_new;
  logic [RPW-1:0] ring_pos_nxt;

  assign ring_total_new = ring_total_q - RTW'(ring_q[ring_pos_q]) + RTW'(sq_root);
  assign ring_pos_nxt   = (ring_pos_q == RPW'(AVG_LENGTH - 1)) ? '0 : ring_pos_q + RPW'(1);

  // ---------------------------------------------------------------- motion / intent decisions
  logic [RTW-1:0] enter_lim, exit_lim;
  logic [3:0]     enter_inc, exit_inc;
  logic [31:0]    gap_age, ref_age, eff;
  logic           gap_ok;
  logic           moving_d, intent_d;
  logic [3:0]     enter_tally_d, exit_tally_d;
  logic [31:0]    bout_d, last_motion_d, last_intent_d;

  assign enter_lim = RTW'(enter_thr_q) * RTW'(AVG_LENGTH);
  assign exit_lim  = RTW'(exit_thr_q) * RTW'(AVG_LENGTH);
  assign enter_inc = enter_tally_q + 4'd1;
  assign exit_inc  = exit_tally_q + 4'd1;
  assign gap_age   = in_q.time_ms - last_motion_q;
  assign ref_age   = in_q.time_ms - last_intent_q;
  assign gap_ok    = gap_age <= 32'(gap_q);
  assign eff       = (moving_q || gap_ok) ? (in_q.time_ms - bout_q) : '0;

  always_comb begin
    moving_d      = moving_q;
    intent_d      = intent_q;
    enter_tally_d = enter_tally_q;
    exit_tally_d  = exit_tally_q;
    bout_d        = bout_q;
    last_motion_d = last_motion_q;
    last_intent_d = last_intent_q;
    case (state_q)
      amid_pkg::ST_HYST: begin
        if (!moving_q) begin
          if (ring_total_q > enter_lim) begin
            enter_tally_d = enter_inc;
            if (enter_inc >= enter_deb_q) begin
              moving_d      = 1'b1;
              enter_tally_d = '0;
              exit_tally_d  = '0;
              bout_d        = in_q.time_ms;
              last_motion_d = in_q.time_ms;
            end
          end else begin
            enter_tally_d = '0;
          end
        end else begin
          // moving: stamp motion time before the exit test
          last_motion_d = in_q.time_ms;
          if (ring_total_q < exit_lim) begin
            exit_tally_d = exit_inc;
            if (exit_inc >= exit_deb_q) begin
              moving_d      = 1'b0;
              exit_tally_d  = '0;
              enter_tally_d = '0;
            end
          end else begin
            exit_tally_d = '0;
          end
        end
      end
      amid_pkg::ST_INTENT: begin
        if (!intent_q && eff >= 32'(intent_min_q) && ref_age >= 32'(refr_q)) begin
          intent_d      = 1'b1;
          last_intent_d = in_q.time_ms;
        end
        // still for longer than the gap: bout over
        if (!moving_q && !gap_ok) begin
          intent_d = 1'b0;
          bout_d   = '0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != amid_pkg::ST_IDLE);
    unique case (state_q)
      amid_pkg::ST_IDLE:   if (in_valid_i) state_d = amid_pkg::ST_MUL_A;
      amid_pkg::ST_MUL_A:  state_d = amid_pkg::ST_MUL_B;
      amid_pkg::ST_MUL_B:  state_d = amid_pkg::ST_GRAV;
      amid_pkg::ST_GRAV:   state_d = amid_pkg::ST_MUL_D;
      amid_pkg::ST_MUL_D:  state_d = amid_pkg::ST_MUL_R;
      amid_pkg::ST_MUL_R:  state_d = (axis_q == amid_pkg::AXIS_LAST) ?
                                     amid_pkg::ST_LIN : amid_pkg::ST_MUL_A;
      amid_pkg::ST_LIN:    if (!sq_busy) state_d = amid_pkg::ST_RING;
      amid_pkg::ST_RING:   state_d = amid_pkg::ST_DIV;
      amid_pkg::ST_DIV:    if (!sq_busy) state_d = amid_pkg::ST_HYST;
      amid_pkg::ST_HYST:   state_d = amid_pkg::ST_INTENT;
      amid_pkg::ST_INTENT: state_d = amid_pkg::ST_EMIT;
      amid_pkg::ST_EMIT:   if (out_free) state_d = amid_pkg::ST_IDLE;
      default:             state_d = amid_pkg::ST_IDLE;
    endcase
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0]     <= '0;
      grav_q[1]     <= '0;
      grav_q[2]     <= GRAV_Z_RST;
      for (int i = 0; i < AVG_LENGTH; i++) ring_q[i] <= '0;
      ring_pos_q    <= '0;
      ring_total_q  <= '0;
      moving_q      <= 1'b0;
      intent_q      <= 1'b0;
      enter_tally_q <= '0;
      exit_tally_q  <= '0;
      bout_q        <= '0;
      last_motion_q <= '0;
      last_intent_q <= '0;
      axis_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      moving_q      <= moving_d;
      intent_q      <= intent_d;
      enter_tally_q <= enter_tally_d;
      exit_tally_q  <= exit_tally_d;
      bout_q        <= bout_d;
      last_motion_q <= last_motion_d;
      last_intent_q <= last_intent_d;

      if (in_acc) axis_q <= '0;
      else if (state_q == amid_pkg::ST_MUL_R) axis_q <= axis_q + 2'd1;

      if (state_q == amid_pkg::ST_GRAV) grav_q[axis_q] <= acc_sh[GW-1:0];

      if (state_q == amid_pkg::ST_RING) begin
        ring_q[ring_pos_q] <= sq_root;
        ring_pos_q         <= ring_pos_nxt;
        ring_total_q       <= ring_total_new;
      end

      if (state_q == amid_pkg::ST_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i)         out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q      <= in_word_i;
      lin_sum_q <= '0;
      raw_sum_q <= '0;
    end
    case (state_q)
      amid_pkg::ST_MUL_A: acc_q     <= (PW+1)'(prod);
      amid_pkg::ST_MUL_B: acc_q     <= acc_q + (PW+1)'(prod) + (PW+1)'(32768);
      amid_pkg::ST_MUL_D: lin_sum_q <= lin_sum_q + SSW'($unsigned(prod));
      amid_pkg::ST_MUL_R: raw_sum_q <= raw_sum_q + prod[31:0];
      amid_pkg::ST_DIV:   num_q     <= prod[RCP_K +: 17];
      amid_pkg::ST_EMIT: begin
        if (out_free) begin
          out_word_q.is_moving           <= moving_q;
          out_word_q.intent_flag         <= intent_q;
          out_word_q.smoothed_linear_mag <= num_q;
          out_word_q.total_mag           <= sq_root;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------- checks
  `AMID_ASSERT_NXT(a_accept_starts, in_acc, state_q == amid_pkg::ST_MUL_A,
                   "accepted word did not start the multiply sequence")
  `AMID_ASSERT_IMP(a_ring_pos_range, 1'b1, ring_pos_q <= RPW'(AVG_LENGTH - 1),
                   "ring position out of range")
  `AMID_ASSERT_IMP(a_idle_root_quiet, state_q == amid_pkg::ST_IDLE, !sq_busy,
                   "square root busy while idle")
  `AMID_ASSERT_IMP(a_out_from_emit, $rose(out_valid_q), $past(state_q == amid_pkg::ST_EMIT),
                   "result word raised outside the emit step")

endmodule

`default_nettype wire

>>> rtl/core/amid_isqrt.sv
`default_nettype none

// Floor square root, one result bit per cycle.
module amid_isqrt (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [amid_pkg::SQRT_IN_W-1:0] radicand_i,
  output logic                                busy_o,
  output logic      [amid_pkg::ROOT_W-1:0]    root_o
);

  localparam int W = amid_pkg::SQRT_IN_W;

  logic         busy_q;
  logic [4:0]   cnt_q;
  logic [W-1:0] x_q;
  logic [W-1:0] res_q;
  logic [W-1:0] step_w;
  logic [W-1:0] trial;
  logic         fits;

  assign step_w = W'(1) << {cnt_q, 1'b0};
  assign trial  = res_q + step_w;
  assign fits   = x_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(amid_pkg::ROOT_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      res_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + step_w;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[amid_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire
